### design/assert_macros.svh
// Assertion macros for the design file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge and disabled in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge and disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### design/swm_pkg.sv
// Package with the constants and register map of the sliding window maximum block.
package swm_pkg;

	localparam int WS_WIDTH   = 6;
	localparam int OUT_WIDTH  = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [APB_ADDR_W-3:0] REG_WINDOW_SIZE = '0;
	localparam logic [WS_WIDTH-1:0]   WS_RESET        = 6'd1;

endpackage

### design/swm_cell.sv
// One cell of the running-maximum chain: holds the maximum over its prefix of the window.
module swm_cell #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           shift_en,
	input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
	input  logic signed [SAMPLE_WIDTH-1:0] prev_max,
	output logic signed [SAMPLE_WIDTH-1:0] run_max
);

	logic signed [SAMPLE_WIDTH-1:0] run_max_q;
	logic signed [SAMPLE_WIDTH-1:0] max_next;

	// After a shift this cell covers the new sample plus everything its left neighbor covered.
	assign max_next = (new_sample > prev_max) ? new_sample : prev_max;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			run_max_q <= max_next;
		end
	end

	assign run_max = run_max_q;

endmodule

### design/sliding_window_maximum.sv
// Top level of the sliding window maximum block: cell chain, fill counter, APB register, output.
// A result is registered at the edge that accepts its sample. Throughput: one item per cycle
// unless the output stalls, set by the single compare in each cell of the chain.
// An input item is taken whenever the output register is empty or being emptied.
// Reset clears the fill count and output valid and sets window_size to 1; cells need no reset.
module sliding_window_maximum #(
	parameter int WINDOW_MAX   = 32,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Sample channel.
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]          sample,
	input  logic                                    restart,
	// Result channel.
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [swm_pkg::OUT_WIDTH-1:0]    window_max,
	// Configuration port.
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [swm_pkg::APB_ADDR_W-1:0]          paddr,
	input  logic [swm_pkg::APB_DATA_W-1:0]          pwdata,
	output logic [swm_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready
);

	import swm_pkg::*;

	`include "assert_macros.svh"

	localparam int CntW = $clog2(WINDOW_MAX + 1);
	localparam int CmpW = (CntW > WS_WIDTH) ? CntW : WS_WIDTH;
	localparam int IdxW = $clog2(WINDOW_MAX);
	localparam int ExtW = (SAMPLE_WIDTH > OUT_WIDTH) ? SAMPLE_WIDTH : OUT_WIDTH;

	// ------------------------------------------------------------------
	// Configuration register. Only window_size exists; writes to any other
	// word are dropped and read back as zero.
	// ------------------------------------------------------------------
	logic [WS_WIDTH-1:0] window_size_q;
	logic                reg_hit;
	logic                cfg_write;

	assign pready    = 1'b1;
	assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_SIZE);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
		end else if (cfg_write && reg_hit) begin
			window_size_q <= pwdata[WS_WIDTH-1:0];
		end
	end

	assign prdata = reg_hit ? APB_DATA_W'(window_size_q) : '0;

	// ------------------------------------------------------------------
	// Effective window: a size of zero acts as one sample, and sizes above
	// the chain length are clamped to the chain length.
	// ------------------------------------------------------------------
	logic [CmpW-1:0] ws_ext;
	logic [CmpW-1:0] eff_w;
	logic [CmpW-1:0] eff_m2;
	logic [IdxW-1:0] tap_idx;

	assign ws_ext = CmpW'(window_size_q);

	always_comb begin
		if (ws_ext == '0) begin
			eff_w = CmpW'(1);
		end else if (ws_ext > CmpW'(WINDOW_MAX)) begin
			eff_w = CmpW'(WINDOW_MAX);
		end else begin
			eff_w = ws_ext;
		end
	end

	// The tap is only used when the window holds two or more samples, so the
	// wrapped value for a window of one is never selected.
	assign eff_m2  = eff_w - CmpW'(2);
	assign tap_idx = eff_m2[IdxW-1:0];

	// ------------------------------------------------------------------
	// Handshake. The output register parts the two channels: a new item is
	// taken whenever the register is empty or its item leaves this cycle.
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic advance;
	logic in_accept;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = !advance;
	assign in_accept = in_valid && advance;

	// ------------------------------------------------------------------
	// Fill count: samples since the last restart, saturating at the chain
	// length. A restart sample counts as the first of its sequence.
	// ------------------------------------------------------------------
	logic [CntW-1:0] fill_q;
	logic [CntW-1:0] fill_next;
	logic            result_now;

	always_comb begin
		if (restart) begin
			fill_next = CntW'(1);
		end else if (fill_q == CntW'(WINDOW_MAX)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + CntW'(1);
		end
	end

	assign result_now = (CmpW'(fill_next) >= eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_accept) begin
			fill_q <= fill_next;
		end
	end

	// ------------------------------------------------------------------
	// Cell chain. Cell i holds the maximum of the i+1 newest samples. On
	// every accepted item each cell takes the maximum of the new sample and
	// its left neighbor's value, so the whole chain moves one step per item.
	// Cell 0 sees the new sample on both inputs and simply loads it. Entries
	// older than the last restart may hold stale values, but a result is only
	// formed once every covered sample belongs to the current sequence.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_WIDTH-1:0] cell_max [WINDOW_MAX];
	logic signed [SAMPLE_WIDTH-1:0] cell_prev [WINDOW_MAX];

	assign cell_prev[0] = sample;

	for (genvar gi = 1; gi < WINDOW_MAX; gi++) begin : g_link
		assign cell_prev[gi] = cell_max[gi-1];
	end

	for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.shift_en   (in_accept),
			.new_sample (sample),
			.prev_max   (cell_prev[gi]),
			.run_max    (cell_max[gi])
		);
	end

	// ------------------------------------------------------------------
	// Result. The window after this sample is the new sample plus the
	// w-1 samples before it, whose maximum already sits in cell w-2.
	// ------------------------------------------------------------------
	logic signed [SAMPLE_WIDTH-1:0] tap_val;
	logic signed [SAMPLE_WIDTH-1:0] cand;
	logic signed [SAMPLE_WIDTH-1:0] result;
	logic [ExtW-1:0]                result_ext;
	logic signed [OUT_WIDTH-1:0]    window_max_q;

	assign tap_val    = cell_max[tap_idx];
	assign cand       = (tap_val > sample) ? tap_val : sample;
	assign result     = (eff_w == CmpW'(1)) ? sample : cand;
	// The result field carries the low bits of the sample pattern; narrower
	// samples are padded with zeros.
	assign result_ext = ExtW'($unsigned(result));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_accept && result_now;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && result_now) begin
			window_max_q <= result_ext[OUT_WIDTH-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`ASSERT_IMPL(a_stall_needs_held_result, clk, arst_n, in_stall, out_valid_q && out_stall)
	`ASSERT_NEXT(a_full_window_gives_result, clk, arst_n, in_accept && result_now, out_valid_q)
	`ASSERT_NEXT(a_restart_holds_back_result, clk, arst_n,
		in_accept && restart && (eff_w > CmpW'(1)), !out_valid_q)
	`ASSERT_IMPL(a_fill_in_range, clk, arst_n, 1'b1, fill_q <= CntW'(WINDOW_MAX))

endmodule
